/* design/tlv_stream_validator_unit_defines.svh */
// ----------------------------------------------------------------------------
// TLV stream validator assertion macros
// Clocked, reset-qualified assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef TLV_STREAM_VALIDATOR_UNIT_DEFINES_SVH
`define TLV_STREAM_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TLV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlv stream validator check failed");

// next-cycle implication
`define TLV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlv stream validator check failed");

`endif

/* design/tlv_pkg.sv */
// ----------------------------------------------------------------------------
// TLV stream validator package
// Shared types, codes and sizes for the parser, event queue and output stage.
// ----------------------------------------------------------------------------
package tlv_pkg;

  localparam int LEN_BITS     = 32;
  localparam int HEADER_BYTES = 32;
  localparam int ENTRY_BYTES  = 16;
  localparam int ENTRY_SHIFT  = $clog2(ENTRY_BYTES);
  localparam int TYPE_COUNT   = 64;

  // power of two, at least 2
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [LEN_BITS-1:0] len_t;

  localparam logic [4:0] IDX_TYPE_END  = 5'd7;
  localparam logic [4:0] IDX_COUNT_END = 5'd15;
  localparam logic [4:0] IDX_RSVD_END  = 5'd23;
  localparam logic [4:0] IDX_HDR_END   = 5'(HEADER_BYTES - 1);
  localparam logic [4:0] IDX_FIELD_END = 5'd7;
  localparam logic [4:0] IDX_ENT_END   = 5'(ENTRY_BYTES - 1);

  typedef enum logic [1:0] {
    CFG_TYPE_LIMIT   = 2'd0,
    CFG_FIELD_LIMIT  = 2'd1,
    CFG_PROCESS_MASK = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_ENT,
    PH_DATA,
    PH_SKIP,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_TYPE   = 3'd1,
    ST_RESERVED   = 3'd2,
    ST_TRUNCATED  = 3'd3,
    ST_MANY       = 3'd4,
    ST_OVERRUN    = 3'd5,
    ST_EXCESS     = 3'd6,
    ST_BAD_FIELD  = 3'd7
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] ident;
    logic [31:0] amount;
    logic [7:0]  out_byte;
    logic        processed;
    status_t     status;
    logic        last;
  } tlv_event_t;

  typedef struct packed {
    logic [1:0] num;
    tlv_event_t ev0;
    tlv_event_t ev1;
  } tlv_push_t;

endpackage

/* design/tlv_parse.sv */
// ----------------------------------------------------------------------------
// TLV parser front end
// Holds the configuration, walks headers, entries and bodies one byte at a
// time and produces zero, one or two events per accepted byte.
// ----------------------------------------------------------------------------
module tlv_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 take,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_blob,
  output tlv_pkg::tlv_push_t   push
);

  tlv_pkg::phase_t  phase, phase_next;
  logic [4:0]       byte_index, byte_index_next;
  tlv_pkg::status_t pend, pend_next;
  logic [63:0]      word_shift, word_shift_next;
  logic [5:0]       record_type, record_type_next;
  tlv_pkg::len_t    entry_count_held, entry_count_held_next;
  tlv_pkg::len_t    record_left, record_left_next;
  tlv_pkg::len_t    entries_left, entries_left_next;
  logic [15:0]      entry_field_held, entry_field_held_next;
  tlv_pkg::len_t    entry_left, entry_left_next;

  logic [6:0]       type_limit;
  logic [15:0]      field_limit;
  logic [63:0]      process_mask;

  logic [63:0]          ws;
  logic [6:0]           type_lim;
  logic                 proc;
  logic                 do_fail;
  logic                 run_after;
  tlv_pkg::status_t     fail_code;
  logic [1:0]           num;
  tlv_pkg::tlv_event_t  ev [2];

  function automatic tlv_pkg::tlv_event_t mk_event(
    input tlv_pkg::kind_t   k,
    input logic [15:0]      id,
    input logic [31:0]      amt,
    input logic [7:0]       b,
    input logic             p,
    input tlv_pkg::status_t st
  );
    tlv_pkg::tlv_event_t e;
    e.kind      = k;
    e.ident     = id;
    e.amount    = amt;
    e.out_byte  = b;
    e.processed = p;
    e.status    = st;
    e.last      = (k == tlv_pkg::KIND_END);
    return e;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      type_limit   <= 7'd1;
      field_limit  <= 16'd1;
      process_mask <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        tlv_pkg::CFG_TYPE_LIMIT:   type_limit   <= cfg_data[6:0];
        tlv_pkg::CFG_FIELD_LIMIT:  field_limit  <= cfg_data[15:0];
        tlv_pkg::CFG_PROCESS_MASK: process_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= tlv_pkg::PH_HDR;
      byte_index       <= '0;
      pend             <= tlv_pkg::ST_OK;
      word_shift       <= '0;
      record_type      <= '0;
      entry_count_held <= '0;
      record_left      <= '0;
      entries_left     <= '0;
      entry_field_held <= '0;
      entry_left       <= '0;
    end else if (take) begin
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      pend             <= pend_next;
      word_shift       <= word_shift_next;
      record_type      <= record_type_next;
      entry_count_held <= entry_count_held_next;
      record_left      <= record_left_next;
      entries_left     <= entries_left_next;
      entry_field_held <= entry_field_held_next;
      entry_left       <= entry_left_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    pend_next             = pend;
    word_shift_next       = word_shift;
    record_type_next      = record_type;
    entry_count_held_next = entry_count_held;
    record_left_next      = record_left;
    entries_left_next     = entries_left;
    entry_field_held_next = entry_field_held;
    entry_left_next       = entry_left;

    ws        = {word_shift[55:0], in_byte};
    type_lim  = (type_limit > 7'(tlv_pkg::TYPE_COUNT)) ? 7'(tlv_pkg::TYPE_COUNT) : type_limit;
    proc      = process_mask[record_type];
    do_fail   = 1'b0;
    run_after = 1'b0;
    fail_code = tlv_pkg::ST_OK;
    num       = 2'd0;
    ev[0]     = '0;
    ev[1]     = '0;

    unique case (phase)
      tlv_pkg::PH_HDR: begin
        word_shift_next = ws;
        byte_index_next = byte_index + 5'd1;
        if (byte_index == tlv_pkg::IDX_TYPE_END) begin
          if (ws >= 64'(type_lim)) begin
            pend_next = tlv_pkg::ST_BAD_TYPE;
          end else begin
            record_type_next = ws[5:0];
          end
        end else if (byte_index == tlv_pkg::IDX_COUNT_END) begin
          entry_count_held_next = ((ws >> tlv_pkg::LEN_BITS) != 64'd0) ? '1 :
                                  tlv_pkg::len_t'(ws);
        end else if (byte_index == tlv_pkg::IDX_RSVD_END) begin
          if (ws != 64'd0 && pend == tlv_pkg::ST_OK) begin
            pend_next = tlv_pkg::ST_RESERVED;
          end
        end else if (byte_index == tlv_pkg::IDX_HDR_END) begin
          byte_index_next = '0;
          if (pend != tlv_pkg::ST_OK) begin
            do_fail   = 1'b1;
            fail_code = pend;
          end else if ((ws >> tlv_pkg::LEN_BITS) != 64'd0 ||
                       (end_of_blob && ws != 64'd0)) begin
            do_fail   = 1'b1;
            fail_code = tlv_pkg::ST_TRUNCATED;
          end else begin
            ev[num[0]] = mk_event(tlv_pkg::KIND_HDR, 16'(record_type),
                                  32'(entry_count_held), 8'd0, proc, tlv_pkg::ST_OK);
            num = num + 2'd1;
            record_left_next = tlv_pkg::len_t'(ws);
            if (proc) begin
              if (entry_count_held > (record_left_next >> tlv_pkg::ENTRY_SHIFT)) begin
                do_fail   = 1'b1;
                fail_code = tlv_pkg::ST_MANY;
              end else begin
                entries_left_next = entry_count_held;
                run_after         = 1'b1;
              end
            end else begin
              phase_next = (record_left_next != '0) ? tlv_pkg::PH_SKIP : tlv_pkg::PH_HDR;
            end
          end
        end
      end
      tlv_pkg::PH_ENT: begin
        record_left_next = record_left - tlv_pkg::len_t'(1);
        word_shift_next  = ws;
        byte_index_next  = byte_index + 5'd1;
        if (byte_index == tlv_pkg::IDX_FIELD_END) begin
          if (ws >= 64'(field_limit)) begin
            pend_next = tlv_pkg::ST_BAD_FIELD;
          end else begin
            entry_field_held_next = ws[15:0];
          end
        end else if (byte_index == tlv_pkg::IDX_ENT_END) begin
          byte_index_next = '0;
          if (pend != tlv_pkg::ST_OK) begin
            do_fail   = 1'b1;
            fail_code = pend;
          end else if (ws > 64'(record_left_next)) begin
            do_fail   = 1'b1;
            fail_code = tlv_pkg::ST_OVERRUN;
          end else begin
            ev[num[0]] = mk_event(tlv_pkg::KIND_ENTRY, entry_field_held, 32'(ws),
                                  8'd0, 1'b0, tlv_pkg::ST_OK);
            num = num + 2'd1;
            entries_left_next = entries_left - tlv_pkg::len_t'(1);
            if (ws == 64'd0) begin
              run_after = 1'b1;
            end else begin
              entry_left_next = tlv_pkg::len_t'(ws);
              phase_next      = tlv_pkg::PH_DATA;
            end
          end
        end
      end
      tlv_pkg::PH_DATA: begin
        ev[num[0]] = mk_event(tlv_pkg::KIND_DATA, entry_field_held, 32'd0, in_byte,
                              1'b0, tlv_pkg::ST_OK);
        num = num + 2'd1;
        entry_left_next  = entry_left - tlv_pkg::len_t'(1);
        record_left_next = record_left - tlv_pkg::len_t'(1);
        if (entry_left_next == '0) begin
          run_after = 1'b1;
        end
      end
      tlv_pkg::PH_SKIP: begin
        record_left_next = record_left - tlv_pkg::len_t'(1);
        if (record_left_next == '0) begin
          phase_next = tlv_pkg::PH_HDR;
        end
      end
      tlv_pkg::PH_DISCARD: ;
      default: begin
        phase_next = tlv_pkg::PH_HDR;
      end
    endcase

    // after a header or an entry: first or next entry, end of record, or error
    if (run_after) begin
      if (entries_left_next == '0) begin
        if (record_left_next == '0) begin
          phase_next = tlv_pkg::PH_HDR;
        end else begin
          do_fail   = 1'b1;
          fail_code = tlv_pkg::ST_EXCESS;
        end
      end else if (record_left_next < tlv_pkg::len_t'(tlv_pkg::ENTRY_BYTES)) begin
        do_fail   = 1'b1;
        fail_code = tlv_pkg::ST_OVERRUN;
      end else begin
        phase_next      = tlv_pkg::PH_ENT;
        byte_index_next = '0;
      end
    end

    if (do_fail) begin
      ev[num[0]] = mk_event(tlv_pkg::KIND_END, 16'd0, 32'd0, 8'd0, 1'b0, fail_code);
      num = num + 2'd1;
      if (end_of_blob) begin
        phase_next      = tlv_pkg::PH_HDR;
        byte_index_next = '0;
        pend_next       = tlv_pkg::ST_OK;
      end else begin
        phase_next = tlv_pkg::PH_DISCARD;
      end
    end else if (end_of_blob) begin
      if (phase != tlv_pkg::PH_DISCARD) begin
        ev[num[0]] = mk_event(tlv_pkg::KIND_END, 16'd0, 32'd0, 8'd0, 1'b0,
                              (phase_next == tlv_pkg::PH_HDR && byte_index_next == '0) ?
                              tlv_pkg::ST_OK : tlv_pkg::ST_TRUNCATED);
        num = num + 2'd1;
      end
      phase_next      = tlv_pkg::PH_HDR;
      byte_index_next = '0;
      pend_next       = tlv_pkg::ST_OK;
    end

    push.num = num;
    push.ev0 = ev[0];
    push.ev1 = ev[1];
  end

endmodule

/* design/tlv_evq.sv */
// ----------------------------------------------------------------------------
// TLV event queue
// Small queue between parser and output stage: takes up to two events per
// cycle, gives one per cycle while the output stage pops.
// ----------------------------------------------------------------------------
module tlv_evq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_en,
  input  tlv_pkg::tlv_push_t    push,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output tlv_pkg::tlv_event_t   head
);

  tlv_pkg::tlv_event_t         slots [tlv_pkg::QUEUE_DEPTH];
  logic [tlv_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [tlv_pkg::QCNT_W-1:0]  count;
  logic [1:0]                  n_in;

  assign n_in      = push_en ? push.num : 2'd0;
  assign full      = count > tlv_pkg::QCNT_W'(tlv_pkg::QUEUE_DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      slots[wr_ptr] <= push.ev0;
    end
    if (n_in == 2'd2) begin
      slots[wr_ptr + tlv_pkg::QPTR_W'(1)] <= push.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tlv_pkg::QPTR_W'(n_in);
      rd_ptr <= rd_ptr + tlv_pkg::QPTR_W'(pop);
      count  <= count + tlv_pkg::QCNT_W'(n_in) - tlv_pkg::QCNT_W'(pop);
    end
  end

endmodule

/* design/tlv_emit.sv */
// ----------------------------------------------------------------------------
// TLV output stage
// Pulls events from the queue into the result register and holds them
// while the consumer stalls.
// ----------------------------------------------------------------------------
module tlv_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 not_empty,
  input  tlv_pkg::tlv_event_t  head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [1:0]           kind,
  output logic [15:0]          ident,
  output logic [31:0]          amount,
  output logic [7:0]           out_byte,
  output logic                 processed,
  output logic [2:0]           status,
  output logic                 last
);

  tlv_pkg::tlv_event_t held;

  assign pop = not_empty && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head;
    end
  end

  assign kind      = held.kind;
  assign ident     = held.ident;
  assign amount    = held.amount;
  assign out_byte  = held.out_byte;
  assign processed = held.processed;
  assign status    = held.status;
  assign last      = held.last;

endmodule

/* design/tlv_stream_validator_unit.sv */
// ----------------------------------------------------------------------------
// TLV stream validator
// Checks a byte stream of type-length-value records and reports header,
// entry, data-byte and end-of-blob events.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// item     item_valid/stall     in_byte, end_of_blob
// result   result_valid/stall   kind, ident, amount, out_byte, processed,
//                               status, last
// cfg      cfg_valid/ready      cfg_index, cfg_data
//
// One byte is accepted per cycle while item_stall is low; the parser finishes
// each byte in that cycle. Results leave one per cycle through the output
// register while result_stall is low; extra results wait in a 4-entry queue.
// item_stall rises while the queue has fewer than two free slots.
// Reset is synchronous: parser waits for a record header, queue and output
// are empty, type_limit = 1, field_limit = 1, process_mask all ones.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module tlv_stream_validator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_blob,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [15:0] ident,
  output logic [31:0] amount,
  output logic [7:0]  out_byte,
  output logic        processed,
  output logic [2:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  tlv_pkg::tlv_push_t  push;
  tlv_pkg::tlv_event_t head;
  logic                take;
  logic                q_full;
  logic                q_not_empty;
  logic                pop;

  assign cfg_ready  = 1'b1;
  assign item_stall = q_full;
  assign take       = item_valid && !q_full;

  tlv_front u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .take        (take),
    .in_byte     (in_byte),
    .end_of_blob (end_of_blob),
    .push        (push)
  );

  tlv_evq u_evq (
    .clk       (clk),
    .rst       (rst),
    .push_en   (take),
    .push      (push),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  tlv_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (q_not_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .ident        (ident),
    .amount       (amount),
    .out_byte     (out_byte),
    .processed    (processed),
    .status       (status),
    .last         (last)
  );

endmodule

/* design/tlv_stream_validator_unit_checker.sv */
// ----------------------------------------------------------------------------
// TLV stream validator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "tlv_stream_validator_unit_defines.svh"

module tlv_stream_validator_unit_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  kind,
  input logic [15:0] ident,
  input logic [31:0] amount,
  input logic [7:0]  out_byte,
  input logic        processed,
  input logic [2:0]  status,
  input logic        last
);

  logic [62:0] res_word;

  assign res_word = {kind, ident, amount, out_byte, processed, status, last};

  `TLV_ASSERT_NEXT(a_stall_hold, result_valid && result_stall, result_valid && $stable(res_word))
  `TLV_ASSERT_NOW(a_last_on_end, result_valid, last == (kind == tlv_pkg::KIND_END))
  `TLV_ASSERT_NOW(a_status_on_end, result_valid && kind != tlv_pkg::KIND_END, status == tlv_pkg::ST_OK)
  `TLV_ASSERT_NOW(a_proc_on_hdr, result_valid && kind != tlv_pkg::KIND_HDR, !processed)

endmodule

bind tlv_stream_validator_unit tlv_stream_validator_unit_checker u_checker (.*);

/* test/tlv_stream_validator_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLV stream validator testbench
// Feeds blobs of type-length-value records, well-formed ones with random
// content plus damaged, truncated and noise blobs, in random bursts. A
// built-in parser predicts every event, and each event taken from the block
// is compared field by field against it while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tlv_stream_validator_unit_tb;
  import tlv_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } blob_byte_t;

  localparam logic [63:0] LEN_MAX = (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        end_of_blob = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] ident;
  logic [31:0] amount;
  logic [7:0]  out_byte;
  logic        processed;
  logic [2:0]  status;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  tlv_stream_validator_unit u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .in_byte(in_byte), .end_of_blob(end_of_blob),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .ident(ident), .amount(amount), .out_byte(out_byte),
    .processed(processed), .status(status), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  blob_byte_t  blob_bytes[$];
  logic [7:0]  staging[$];
  tlv_event_t  due_events[$];
  tlv_event_t  want;
  blob_byte_t  nb;
  int          error_count = 0;
  int          sent_bytes = 0;
  bit          item_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          stall_span = 0;
  int unsigned stall_tick = 0;

  // parser copy of the registers and state
  logic [6:0]  cur_type_limit;
  logic [15:0] cur_field_limit;
  logic [63:0] cur_mask;
  phase_t      ph;
  int unsigned hdr_idx;
  logic [63:0] shreg, count_held, rec_left, ent_pending, ent_left;
  logic [5:0]  rec_type;
  logic [15:0] field_held;
  logic        dropping, ended_now, eob_now;
  status_t     pend_status;

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void push_event(kind_t k, logic [15:0] id, logic [31:0] amt,
                                     logic [7:0] ob, logic pr, status_t st, logic lst);
    tlv_event_t ev;
    ev.kind = k;
    ev.ident = id;
    ev.amount = amt;
    ev.out_byte = ob;
    ev.processed = pr;
    ev.status = st;
    ev.last = lst;
    due_events.push_back(ev);
  endfunction

  function automatic void fresh_blob();
    ph = PH_HDR;
    hdr_idx = 0;
    pend_status = ST_OK;
    dropping = 1'b0;
  endfunction

  function automatic void abort(status_t code);
    push_event(KIND_END, 16'd0, 32'd0, 8'd0, 1'b0, code, 1'b1);
    ended_now = 1'b1;
    if (eob_now) begin
      fresh_blob();
    end else begin
      ph = PH_DISCARD;
      dropping = 1'b1;
    end
  endfunction

  function automatic void next_entry();
    if (ent_pending == 0) begin
      if (rec_left == 0) ph = PH_HDR;
      else abort(ST_EXCESS);
    end else if (rec_left < ENTRY_BYTES) begin
      abort(ST_OVERRUN);
    end else begin
      ph = PH_ENT;
      hdr_idx = 0;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eob);
    int unsigned idx;
    logic [63:0] lim;
    logic        proc;
    ended_now = 1'b0;
    eob_now = eob;
    if (ph == PH_DISCARD || dropping) begin
      if (eob) fresh_blob();
      return;
    end
    case (ph)
      PH_HDR: begin
        shreg = {shreg[55:0], b};
        idx = hdr_idx;
        hdr_idx = (hdr_idx + 1) % 32;
        if (idx == 7) begin
          lim = (cur_type_limit > 64) ? 64'd64 : 64'(cur_type_limit);
          if (shreg >= lim) pend_status = ST_BAD_TYPE;
          else rec_type = shreg[5:0];
        end else if (idx == 15) begin
          count_held = (shreg > LEN_MAX) ? LEN_MAX : shreg;
        end else if (idx == 23) begin
          if (shreg != 0 && pend_status == ST_OK) pend_status = ST_RESERVED;
        end else if (idx == HEADER_BYTES - 1) begin
          hdr_idx = 0;
          if (pend_status != ST_OK) begin
            abort(pend_status);
          end else if (shreg > LEN_MAX || (eob && shreg != 0)) begin
            abort(ST_TRUNCATED);
          end else begin
            proc = cur_mask[rec_type];
            push_event(KIND_HDR, 16'(rec_type), count_held[31:0], 8'd0, proc, ST_OK, 1'b0);
            rec_left = shreg;
            if (proc) begin
              if (count_held > rec_left / ENTRY_BYTES) begin
                abort(ST_MANY);
              end else begin
                ent_pending = count_held;
                next_entry();
              end
            end else begin
              ph = (rec_left != 0) ? PH_SKIP : PH_HDR;
            end
          end
        end
      end
      PH_ENT: begin
        rec_left = (rec_left - 1) & LEN_MAX;
        shreg = {shreg[55:0], b};
        idx = hdr_idx;
        hdr_idx = (hdr_idx + 1) % 32;
        if (idx == 7) begin
          if (shreg >= cur_field_limit) pend_status = ST_BAD_FIELD;
          else field_held = shreg[15:0];
        end else if (idx == ENTRY_BYTES - 1) begin
          hdr_idx = 0;
          if (pend_status != ST_OK) begin
            abort(pend_status);
          end else if (shreg > rec_left) begin
            abort(ST_OVERRUN);
          end else begin
            push_event(KIND_ENTRY, field_held, shreg[31:0], 8'd0, 1'b0, ST_OK, 1'b0);
            ent_pending = (ent_pending - 1) & LEN_MAX;
            if (shreg == 0) begin
              next_entry();
            end else begin
              ent_left = shreg;
              ph = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        push_event(KIND_DATA, field_held, 32'd0, b, 1'b0, ST_OK, 1'b0);
        ent_left = (ent_left - 1) & LEN_MAX;
        rec_left = (rec_left - 1) & LEN_MAX;
        if (ent_left == 0) next_entry();
      end
      default: begin
        rec_left = (rec_left - 1) & LEN_MAX;
        if (rec_left == 0) ph = PH_HDR;
      end
    endcase
    if (!ended_now && eob) begin
      push_event(KIND_END, 16'd0, 32'd0, 8'd0, 1'b0,
                 (ph == PH_HDR && hdr_idx == 0) ? ST_OK : ST_TRUNCATED, 1'b1);
      fresh_blob();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_type_limit = 7'd1;
      cur_field_limit = 16'd1;
      cur_mask = '1;
      shreg = '0;
      count_held = '0;
      rec_left = '0;
      ent_pending = '0;
      ent_left = '0;
      rec_type = '0;
      field_held = '0;
      fresh_blob();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TYPE_LIMIT:   cur_type_limit = cfg_data[6:0];
          CFG_FIELD_LIMIT:  cur_field_limit = cfg_data[15:0];
          CFG_PROCESS_MASK: cur_mask = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        parse_byte(in_byte, end_of_blob);
        item_taken = 1'b1;
      end
      if (result_valid && !result_stall) begin
        if (due_events.size() == 0) begin
          report_error($sformatf("event kind %0d with nothing expected", kind));
        end else begin
          want = due_events.pop_front();
          if (kind !== want.kind)
            report_error($sformatf("kind %0h, expected %0h", kind, want.kind));
          if (ident !== want.ident)
            report_error($sformatf("ident %0h, expected %0h", ident, want.ident));
          if (amount !== want.amount)
            report_error($sformatf("amount %0h, expected %0h", amount, want.amount));
          if (out_byte !== want.out_byte)
            report_error($sformatf("out_byte %0h, expected %0h", out_byte, want.out_byte));
          if (processed !== want.processed)
            report_error($sformatf("processed %0h, expected %0h", processed, want.processed));
          if (status !== want.status)
            report_error($sformatf("status %0h, expected %0h", status, want.status));
          if (last !== want.last)
            report_error($sformatf("last %0h, expected %0h", last, want.last));
        end
      end
    end
  end

  // hold the byte until it is taken, then advance
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (blob_bytes.size() == 0) begin
        item_valid <= 1'b0;
      end else begin
        nb = blob_bytes.pop_front();
        item_valid <= 1'b1;
        in_byte <= nb.data;
        end_of_blob <= nb.eob;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(negedge clk) begin
    stall_tick++;
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(16, 96);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= $urandom_range(0, 1);
      2: result_stall <= ($urandom_range(0, 4) != 0);
      default: result_stall <= (stall_tick % 3 == 0);
    endcase
  end

  function automatic void put_word(logic [63:0] w);
    for (int i = 7; i >= 0; i--) staging.push_back(w[i*8 +: 8]);
  endfunction

  function automatic void put_bytes(int n);
    for (int i = 0; i < n; i++) staging.push_back(8'($urandom));
  endfunction

  function automatic void put_header(logic [63:0] ty, logic [63:0] cnt,
                                     logic [63:0] rsv, logic [63:0] len);
    put_word(ty);
    put_word(cnt);
    put_word(rsv);
    put_word(len);
  endfunction

  function automatic void close_blob();
    blob_byte_t bb;
    for (int i = 0; i < staging.size(); i++) begin
      bb.data = staging[i];
      bb.eob = (i == staging.size() - 1);
      blob_bytes.push_back(bb);
    end
    sent_bytes += staging.size();
    staging.delete();
  endfunction

  function automatic void add_record(bit inject);
    logic [63:0] ty, cnt, rsv, len;
    logic [63:0] fld[4];
    logic [63:0] elen[4];
    int unsigned eff, n, extra;
    logic        proc;
    status_t     inj;
    eff = (cur_type_limit > 64) ? 64 : cur_type_limit;
    inj = inject ? status_t'($urandom_range(1, 7)) : ST_OK;
    if (eff == 0 || inj == ST_BAD_TYPE) begin
      case ($urandom_range(0, 2))
        0: ty = 64'(eff);
        1: ty = 64'(eff + $urandom_range(1, 63));
        default: ty = {$urandom, $urandom} | (64'd1 << 63);
      endcase
    end else begin
      ty = $urandom_range(0, eff - 1);
    end
    proc = cur_mask[ty[5:0]];
    n = $urandom_range(0, 3);
    if (inj == ST_BAD_FIELD && n == 0) n = 1;
    len = 0;
    for (int i = 0; i < n; i++) begin
      fld[i] = (cur_field_limit == 0) ? 64'($urandom)
                                      : 64'($urandom_range(0, cur_field_limit - 1));
      elen[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
      len += ENTRY_BYTES + elen[i];
    end
    cnt = n;
    if (!proc) begin
      len = $urandom_range(0, 24);
      cnt = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : $urandom_range(0, 9);
    end
    if (inj == ST_BAD_FIELD)
      fld[$urandom_range(0, n - 1)] = $urandom_range(0, 1) ?
          64'(cur_field_limit + $urandom_range(0, 3)) : ({$urandom, $urandom} | (64'd1 << 63));
    rsv = (inj == ST_RESERVED) ? ((64'd1 << $urandom_range(0, 63)) | {$urandom, $urandom}) : 0;
    if (inj == ST_TRUNCATED) len = len | (64'd1 << $urandom_range(32, 63));
    if (inj == ST_MANY) cnt = len / ENTRY_BYTES + 1 + $urandom_range(0, 2);
    if (inj == ST_OVERRUN && n > 0) elen[n-1] += $urandom_range(1, 4);
    extra = (inj == ST_EXCESS) ? $urandom_range(1, 20) : 0;
    len += extra;
    put_header(ty, cnt, rsv, len);
    if (inj == ST_TRUNCATED) return;
    if (proc) begin
      for (int i = 0; i < n; i++) begin
        put_word(fld[i]);
        put_word(elen[i]);
        put_bytes(elen[i]);
      end
      put_bytes(extra);
    end else begin
      put_bytes(len);
    end
  endfunction

  function automatic void add_blob();
    int unsigned cut;
    if ($urandom_range(0, 9) == 0) begin
      put_bytes($urandom_range(1, 40));
    end else begin
      for (int r = $urandom_range(1, 3); r > 0; r--) add_record($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, staging.size());
        while (staging.size() > cut) void'(staging.pop_back());
      end
    end
    close_blob();
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (blob_bytes.size() != 0 || item_valid || due_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("FAIL tlv_stream_validator_unit");
    $finish;
  end

  initial begin
    logic [6:0]  tl;
    logic [15:0] fl;
    logic [63:0] pm;
    int          phase_no;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: only type 0 and field 0 are valid, all types parsed
    put_header(0, 1, 0, 18); put_word(0); put_word(2);
    staging.push_back(8'h00); staging.push_back(8'hFF); close_blob();
    put_header(0, 0, 0, 0); close_blob();
    put_header(0, 0, 0, 5); close_blob();
    put_header(1, 0, 0, 0); staging.push_back(8'hA5); close_blob();
    put_header(0, 0, 64'h8000_0000_0000_0000, 0); close_blob();
    put_header(0, 0, 0, 64'h1_0000_0000); close_blob();
    put_header(0, 2, 0, 16); put_word(0); put_word(0); close_blob();
    put_header(0, 1, 0, 17); put_word(0); put_word(2); put_bytes(1); close_blob();
    put_header(0, 1, 0, 19); put_word(0); put_word(0); put_bytes(3); close_blob();
    put_header(0, 1, 0, 16); put_word(1); put_word(0); close_blob();
    staging.push_back(8'h00); close_blob();
    put_header(0, 2, 0, 40); put_word(0); put_word(10); put_bytes(24); close_blob();
    put_header(0, 0, 0, 0); put_header(0, 1, 0, 16); put_word(0); put_word(0); close_blob();
    put_header(0, 1, 0, 20); put_word(0); put_word(4); put_bytes(2); close_blob();
    wait_idle();

    phase_no = 0;
    while (sent_bytes < 1250) begin
      case (phase_no)
        0: begin tl = 7'd64; fl = 16'hFFFF; pm = '1; end
        1: begin tl = 7'd1; fl = 16'd1; pm = '0; end
        2: begin tl = 7'd127; fl = 16'd0; pm = {$urandom, $urandom}; end
        3: begin tl = 7'd0; fl = 16'($urandom_range(1, 65535)); pm = '1; end
        default: begin
          tl = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 64));
          fl = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 12));
          pm = ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom};
        end
      endcase
      write_reg(CFG_TYPE_LIMIT, 64'(tl));
      write_reg(CFG_FIELD_LIMIT, 64'(fl));
      write_reg(CFG_PROCESS_MASK, pm);
      for (int i = 0; i < 2; i++) add_blob();
      wait_idle();
      phase_no++;
    end

    while (blob_bytes.size() != 0 || item_valid || due_events.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS tlv_stream_validator_unit");
    end else begin
      $display("FAIL tlv_stream_validator_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/tlv_pkg.sv
design/tlv_parse.sv
design/tlv_evq.sv
design/tlv_emit.sv
design/tlv_stream_validator_unit.sv
design/tlv_stream_validator_unit_checker.sv
test/tlv_stream_validator_unit_tb.sv
